[hdl/rpc_pkg.sv]
package rpc_pkg;

  // default sizing
  localparam int DEF_MAX_ROOMS = 8;
  localparam int DEF_MAX_VERTS = 16;

  // stream widths
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 88;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROOM_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOM_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_MARGIN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FULL_DIST    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROOMS_IN_USE = 3'd4;

  localparam logic [30:0] RST_ROOM_WIDTH  = 31'd655360;
  localparam logic [30:0] RST_ROOM_HEIGHT = 31'd655360;
  localparam logic [30:0] RST_EDGE_MARGIN = 31'd0;
  localparam logic [30:0] RST_FULL_DIST   = 31'd196608;

  // command codes
  localparam logic [1:0] CMD_WR_VERT  = 2'd0;
  localparam logic [1:0] CMD_WR_ROOM  = 2'd1;
  localparam logic [1:0] CMD_CLASSIFY = 2'd2;

  // last iteration index of the root and divide loops
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd15;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLAMP,
    OP_ROOM_SKIP,
    OP_ROOM_OPEN,
    OP_WAIT0,
    OP_FIRST,
    OP_EDGE,
    OP_MUL_A,
    OP_MUL_B,
    OP_CMP,
    OP_MATCH,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SUM,
    OP_SQRT,
    OP_DCHK,
    OP_DIV,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic classify;
    logic clamp_hit;
    logic room_done;
    logic small_room;
    logic edge_last;
    logic in_poly;
    logic far;
    logic iter_last;
    logic dist_far;
    logic out_free;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_ROOM,
    ST_WAIT0,
    ST_FIRST,
    ST_EDGE,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP,
    ST_END,
    ST_DIFF,
    ST_CHK,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_SQRT,
    ST_DCHK,
    ST_DIV,
    ST_OUT
  } ctrl_state_t;

endpackage

[hdl/rpc_ctrl.sv]
module rpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  rpc_pkg::dp_status_t status,
  output rpc_pkg::dp_cmd_t    cmd
);
  import rpc_pkg::*;

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.accept = 1'b0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid && status.classify) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.op     = OP_CLAMP;
        state_next = status.clamp_hit ? ST_OUT : ST_ROOM;
      end
      ST_ROOM: begin
        if (status.room_done) begin
          state_next = ST_OUT;
        end else if (status.small_room) begin
          cmd.op = OP_ROOM_SKIP;
        end else begin
          cmd.op     = OP_ROOM_OPEN;
          state_next = ST_WAIT0;
        end
      end
      ST_WAIT0: begin
        cmd.op     = OP_WAIT0;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        cmd.op     = OP_FIRST;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.op     = OP_EDGE;
        state_next = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd.op     = OP_MUL_A;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = OP_MUL_B;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.op     = OP_CMP;
        state_next = status.edge_last ? ST_END : ST_EDGE;
      end
      ST_END: begin
        if (status.in_poly) begin
          cmd.op     = OP_MATCH;
          state_next = ST_DIFF;
        end else begin
          cmd.op     = OP_ROOM_SKIP;
          state_next = ST_ROOM;
        end
      end
      ST_DIFF: begin
        cmd.op     = OP_DIFF;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        state_next = status.far ? ST_OUT : ST_SQX;
      end
      ST_SQX: begin
        cmd.op     = OP_SQX;
        state_next = ST_SQY;
      end
      ST_SQY: begin
        cmd.op     = OP_SQY;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.op     = OP_SUM;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (status.iter_last) begin
          state_next = ST_DCHK;
        end
      end
      ST_DCHK: begin
        cmd.op     = OP_DCHK;
        state_next = status.dist_far ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (status.iter_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/rpc_datapath.sv]
module rpc_datapath #(
  parameter int MAX_ROOMS = rpc_pkg::DEF_MAX_ROOMS,
  parameter int MAX_VERTS = rpc_pkg::DEF_MAX_VERTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [rpc_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rpc_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [rpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  rpc_pkg::dp_cmd_t                 cmd,
  output rpc_pkg::dp_status_t              status
);
  import rpc_pkg::*;

  localparam int DEPTH = MAX_ROOMS * MAX_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int RCW   = $clog2(MAX_ROOMS + 1);
  localparam int VW    = $clog2(MAX_VERTS);
  localparam logic [4:0] VCAP = (MAX_VERTS > 31) ? 5'd31 : 5'(MAX_VERTS);

  // input fields
  logic [1:0]         in_cmd;
  logic [2:0]         in_rslot;
  logic [3:0]         in_vslot;
  logic signed [31:0] in_x, in_y;
  logic [4:0]         in_total;

  assign in_cmd   = s_tdata[1:0];
  assign in_rslot = s_tdata[4:2];
  assign in_vslot = s_tdata[8:5];
  assign in_x     = s_tdata[40:9];
  assign in_y     = s_tdata[72:41];
  assign in_total = s_tdata[77:73];

  // configuration registers
  logic [30:0] room_width, room_height, edge_margin, full_dist;
  logic [3:0]  rooms_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      room_width   <= RST_ROOM_WIDTH;
      room_height  <= RST_ROOM_HEIGHT;
      edge_margin  <= RST_EDGE_MARGIN;
      full_dist    <= RST_FULL_DIST;
      rooms_in_use <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOM_WIDTH:   room_width   <= cfg_data;
        CFG_ROOM_HEIGHT:  room_height  <= cfg_data;
        CFG_EDGE_MARGIN:  edge_margin  <= cfg_data;
        CFG_FULL_DIST:    full_dist    <= cfg_data;
        CFG_ROOMS_IN_USE: rooms_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // write decode
  logic          room_ok, vert_ok;
  logic [AW-1:0] wr_addr;
  logic [4:0]    total_sat;

  assign room_ok   = 32'(in_rslot) < 32'(MAX_ROOMS);
  assign vert_ok   = room_ok && (32'(in_vslot) < 32'(MAX_VERTS));
  assign wr_addr   = AW'(32'(in_rslot) * 32'(MAX_VERTS) + 32'(in_vslot));
  assign total_sat = (in_total > VCAP) ? VCAP : in_total;

  // walk registers
  logic [RCW-1:0]     room;
  logic [VW-1:0]      vidx;
  logic [4:0]         ecnt;
  logic               in_poly;
  logic [AW-1:0]      rd_addr;

  assign rd_addr = AW'(32'(room) * 32'(MAX_VERTS) + 32'(vidx));

  // vertex memory, x in the upper half and y in the lower
  logic [63:0] vmem [DEPTH];
  logic [63:0] vrd;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_WR_VERT && vert_ok) begin
      vmem[wr_addr] <= {in_x, in_y};
    end
    vrd <= vmem[rd_addr];
  end

  // centre memory
  logic [63:0] cmem [MAX_ROOMS];
  logic [63:0] crd;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_WR_ROOM && room_ok) begin
      cmem[RIW'(in_rslot)] <= {in_x, in_y};
    end
    crd <= cmem[RIW'(room)];
  end

  // vertex counts, cleared by reset
  logic [4:0] vcnt [MAX_ROOMS];
  logic [4:0] n_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROOMS; i++) begin
        vcnt[i] <= 5'd0;
      end
    end else if (cmd.accept && in_cmd == CMD_WR_ROOM && room_ok) begin
      vcnt[RIW'(in_rslot)] <= total_sat;
    end
  end

  assign n_cur = vcnt[RIW'(room)];

  // point and result registers
  logic signed [31:0] px, py;
  logic               clamped, found;
  logic [2:0]         match;
  logic [16:0]        conf;

  // clamp against the margin box
  logic signed [33:0] mg, xhi, yhi, cx0, cx1, cx2, cy0, cy1, cy2;
  logic               hx1, hx2, hy1, hy2;

  always_comb begin
    mg  = {3'b000, edge_margin};
    xhi = {3'b000, room_width} - mg;
    yhi = {3'b000, room_height} - mg;
    cx0 = {{2{px[31]}}, px};
    cy0 = {{2{py[31]}}, py};
    hx1 = cx0 <= mg;
    cx1 = hx1 ? mg : cx0;
    hx2 = cx1 >= xhi;
    cx2 = hx2 ? xhi : cx1;
    hy1 = cy0 <= mg;
    cy1 = hy1 ? mg : cy0;
    hy2 = cy1 >= yhi;
    cy2 = hy2 ? yhi : cy1;
  end

  // edge registers
  logic signed [31:0] x1, y1, x2, y2, vx, vy;
  logic signed [32:0] d1, d2, d3, d4;

  assign vx = vrd[63:32];
  assign vy = vrd[31:0];

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, prod_a;

  // distance, root and divide registers
  logic [32:0] ax, ay;
  logic [63:0] sq_v, sq_res, sq_bit;
  logic [31:0] dv_r;
  logic [15:0] dv_q;
  logic [4:0]  itc;

  always_comb begin
    case (cmd.op)
      OP_MUL_A: begin
        mul_a = d1;
        mul_b = d2;
      end
      OP_MUL_B: begin
        mul_a = d3;
        mul_b = d4;
      end
      OP_SQX: begin
        mul_a = ax;
        mul_b = ax;
      end
      default: begin
        mul_a = ay;
        mul_b = ay;
      end
    endcase
  end

  // edge test
  logic signed [31:0] ylo, yhi_e, xhi_e;
  logic               in_range, vertical, dy_pos, hit, toggle;
  logic [5:0]         enext;

  always_comb begin
    ylo      = (y1 < y2) ? y1 : y2;
    yhi_e    = (y1 < y2) ? y2 : y1;
    xhi_e    = (x1 < x2) ? x2 : x1;
    in_range = (py > ylo) && (py <= yhi_e) && (px <= xhi_e);
    vertical = x1 == x2;
    dy_pos   = !d2[32] && (d2 != 33'sd0);
    hit      = dy_pos ? (prod_a <= prod) : (prod_a >= prod);
    toggle   = in_range && (vertical || hit);
    enext    = {1'b0, ecnt} + 6'd1;
  end

  // centre offsets
  logic signed [31:0] ccx, ccy;
  logic signed [32:0] dcx, dcy;

  assign ccx = crd[63:32];
  assign ccy = crd[31:0];
  assign dcx = {px[31], px} - {ccx[31], ccx};
  assign dcy = {py[31], py} - {ccy[31], ccy};

  // one root step and one divide step
  logic [63:0] sq_try;
  logic        sq_ge;
  logic [32:0] dv_sh;
  logic        dv_ge;
  logic [15:0] dv_q_next;

  assign sq_try    = sq_res + sq_bit;
  assign sq_ge     = sq_v >= sq_try;
  assign dv_sh     = {dv_r, 1'b0};
  assign dv_ge     = dv_sh >= {2'b00, full_dist};
  assign dv_q_next = {dv_q[14:0], dv_ge};

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept && in_cmd == CMD_CLASSIFY) begin
      px <= in_x;
      py <= in_y;
    end
    case (cmd.op)
      OP_CLAMP: begin
        px      <= cx2[31:0];
        py      <= cy2[31:0];
        clamped <= hx1 || hx2 || hy1 || hy2;
        found   <= 1'b0;
        match   <= 3'd0;
        conf    <= 17'd0;
        room    <= '0;
      end
      OP_ROOM_SKIP: room <= room + RCW'(1);
      OP_ROOM_OPEN: begin
        vidx    <= '0;
        ecnt    <= 5'd1;
        in_poly <= 1'b0;
      end
      OP_WAIT0: vidx <= (n_cur <= 5'd1) ? '0 : VW'(1);
      OP_FIRST: begin
        x1 <= vx;
        y1 <= vy;
      end
      OP_EDGE: begin
        x2 <= vx;
        y2 <= vy;
        d1 <= {px[31], px} - {x1[31], x1};
        d2 <= {vy[31], vy} - {y1[31], y1};
        d3 <= {py[31], py} - {y1[31], y1};
        d4 <= {vx[31], vx} - {x1[31], x1};
      end
      OP_MUL_A: begin
        prod <= mul_a * mul_b;
        vidx <= (enext >= {1'b0, n_cur}) ? '0 : VW'(enext);
      end
      OP_MUL_B: begin
        prod_a <= prod;
        prod   <= mul_a * mul_b;
      end
      OP_CMP: begin
        in_poly <= in_poly ^ toggle;
        x1      <= x2;
        y1      <= y2;
        ecnt    <= enext[4:0];
      end
      OP_MATCH: begin
        found <= 1'b1;
        match <= 3'(room);
      end
      OP_DIFF: begin
        ax <= dcx[32] ? 33'(-dcx) : 33'(dcx);
        ay <= dcy[32] ? 33'(-dcy) : 33'(dcy);
      end
      OP_SQX: prod <= mul_a * mul_b;
      OP_SQY: begin
        prod_a <= prod;
        prod   <= mul_a * mul_b;
      end
      OP_SUM: begin
        sq_v   <= prod_a[63:0] + prod[63:0];
        sq_res <= 64'd0;
        sq_bit <= 64'h4000_0000_0000_0000;
        itc    <= 5'd0;
      end
      OP_SQRT: begin
        if (sq_ge) begin
          sq_v   <= sq_v - sq_try;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        itc    <= itc + 5'd1;
      end
      OP_DCHK: begin
        dv_r <= sq_res[31:0];
        dv_q <= 16'd0;
        itc  <= 5'd0;
      end
      OP_DIV: begin
        dv_r <= dv_ge ? 32'(dv_sh - {2'b00, full_dist}) : dv_sh[31:0];
        dv_q <= dv_q_next;
        conf <= 17'h10000 - {1'b0, dv_q_next};
        itc  <= itc + 5'd1;
      end
      default: ;
    endcase
  end

  // result register
  logic signed [31:0] o_x, o_y;
  logic               o_clamped, o_found;
  logic [2:0]         o_match;
  logic [16:0]        o_conf;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.op == OP_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT && out_free) begin
      o_x       <= px;
      o_y       <= py;
      o_clamped <= clamped;
      o_found   <= found;
      o_match   <= match;
      o_conf    <= conf;
    end
  end

  assign m_tdata = {2'b00, o_conf, o_match, o_found, o_clamped, o_y, o_x};

  // status to the controller
  logic [31:0] limit;

  assign limit = (32'(rooms_in_use) > 32'(MAX_ROOMS)) ? 32'(MAX_ROOMS) : 32'(rooms_in_use);

  always_comb begin
    status.classify   = in_cmd == CMD_CLASSIFY;
    status.clamp_hit  = hx1 || hx2 || hy1 || hy2;
    status.room_done  = 32'(room) >= limit;
    status.small_room = n_cur < 5'd3;
    status.edge_last  = ecnt == n_cur;
    status.in_poly    = in_poly;
    status.far        = (ax >= {2'b00, full_dist}) || (ay >= {2'b00, full_dist});
    status.iter_last  = (cmd.op == OP_SQRT) ? (itc == SQRT_LAST) : (itc == DIV_LAST);
    status.dist_far   = sq_res >= {33'd0, full_dist};
    status.out_free   = out_free;
  end

endmodule

[hdl/room_position_classifier_top.sv]
// channel | direction | payload
// s_*     | in        | cmd, room_slot, vertex_slot, coord_x, coord_y, vertex_total
// m_*     | out       | pos_x, pos_y, was_clamped, room_found, matched_room, confidence
// cfg_*   | in        | register index and write data, no read-back
//
// writes are accepted in the idle state; a classify passes accept, clamp and result, and
// when unclamped steps past each skipped room and tests each edge of each walked room
// (one vertex memory read and two passes through the shared multiplier), and then ends
// the room list when nothing matches; a match adds a root and a divide (32 root steps,
// 16 divide steps), cut short when the point is far from the centre. rst clears control,
// configuration and vertex counts. a result waits in the output register while the
// next transfer is accepted; a stalled result holds the walk in its last state.
module room_position_classifier_top #(
  parameter int MAX_ROOMS = rpc_pkg::DEF_MAX_ROOMS,
  parameter int MAX_VERTS = rpc_pkg::DEF_MAX_VERTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd, room_slot, vertex_slot, coord_x, coord_y, vertex_total
  input  logic [rpc_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pos_x, pos_y, was_clamped, room_found, matched_room, confidence
  output logic [rpc_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [rpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rpc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  rpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // stores, arithmetic and result register
  rpc_datapath #(
    .MAX_ROOMS (MAX_ROOMS),
    .MAX_VERTS (MAX_VERTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import rpc_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NROOMS = DEF_MAX_ROOMS;
  localparam int NVERTS = DEF_MAX_VERTS;
  localparam int SETTLE_CYCLES = 700;

  // one input item, lowest field last
  typedef struct packed {
    logic [4:0]  total;
    logic [31:0] y;
    logic [31:0] x;
    logic [3:0]  vslot;
    logic [2:0]  rslot;
    logic [1:0]  cmd;
  } cmd_item_t;

  // one classification result, lowest field last
  typedef struct packed {
    logic [16:0] conf;
    logic [2:0]  room;
    logic        found;
    logic        clamped;
    logic [31:0] y;
    logic [31:0] x;
  } class_result_t;

  // room store mirror, classification predictor and result queue
  class room_scoreboard;
    logic [31:0] vx[NROOMS*NVERTS];
    logic [31:0] vy[NROOMS*NVERTS];
    logic [31:0] cx[NROOMS];
    logic [31:0] cy[NROOMS];
    logic [4:0]  vcount[NROOMS];
    logic [30:0] width_q, height_q, margin_q, dist_q;
    logic [3:0]  rooms_q;
    class_result_t pending[$];
    int errors;
    int checked;
    int matched;
    int clamped_cnt;

    function void reset_state();
      width_q = RST_ROOM_WIDTH;
      height_q = RST_ROOM_HEIGHT;
      margin_q = RST_EDGE_MARGIN;
      dist_q = RST_FULL_DIST;
      rooms_q = 0;
      foreach (vcount[i]) vcount[i] = 0;
      pending.delete();
      errors = 0;
      checked = 0;
      matched = 0;
      clamped_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [30:0] v);
      case (idx)
        CFG_ROOM_WIDTH:   width_q = v;
        CFG_ROOM_HEIGHT:  height_q = v;
        CFG_EDGE_MARGIN:  margin_q = v;
        CFG_FULL_DIST:    dist_q = v;
        CFG_ROOMS_IN_USE: rooms_q = v[3:0];
        default: ;
      endcase
    endfunction

    // crossing-parity test with exact cross products
    function bit room_contains(int r, longint px, longint py);
      int n;
      int b;
      int k;
      bit ins;
      bit hit;
      longint x1, y1, x2, y2, ylo, yhi, xhi;
      logic signed [67:0] ea, eb, fa, fb, lhs, rhs;
      n = vcount[r];
      b = r * NVERTS;
      ins = 0;
      if (n < 3) return 0;
      x1 = $signed(vx[b]);
      y1 = $signed(vy[b]);
      for (int i = 1; i <= n; i++) begin
        k = b + (i % n);
        x2 = $signed(vx[k]);
        y2 = $signed(vy[k]);
        ylo = (y1 < y2) ? y1 : y2;
        yhi = (y1 < y2) ? y2 : y1;
        xhi = (x1 < x2) ? x2 : x1;
        if (py > ylo && py <= yhi && px <= xhi) begin
          if (x1 == x2) begin
            hit = 1;
          end else begin
            ea = px - x1;
            eb = y2 - y1;
            fa = py - y1;
            fb = x2 - x1;
            lhs = ea * eb;
            rhs = fa * fb;
            hit = (y2 > y1) ? (lhs <= rhs) : (lhs >= rhs);
          end
          if (hit) ins = !ins;
        end
        x1 = x2;
        y1 = y2;
      end
      return ins;
    endfunction

    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function logic [16:0] centre_confidence(int r, longint px, longint py);
      longint unsigned d, ax, ay, root_dist;
      longint dx, dy;
      d = dist_q;
      dx = px - longint'($signed(cx[r]));
      dy = py - longint'($signed(cy[r]));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax >= d || ay >= d) return 0;
      root_dist = floor_root(ax * ax + ay * ay);
      if (root_dist >= d) return 0;
      return 17'(65536 - ((root_dist << 16) / d));
    endfunction

    function void classify_point(cmd_item_t it);
      class_result_t res;
      longint m, xh, yh, px, py;
      int lim;
      m = margin_q;
      xh = longint'(width_q) - m;
      yh = longint'(height_q) - m;
      px = $signed(it.x);
      py = $signed(it.y);
      res = '0;
      lim = (rooms_q > NROOMS) ? NROOMS : rooms_q;
      if (px <= m) begin px = m; res.clamped = 1; end
      if (px >= xh) begin px = xh; res.clamped = 1; end
      if (py <= m) begin py = m; res.clamped = 1; end
      if (py >= yh) begin py = yh; res.clamped = 1; end
      if (!res.clamped) begin
        for (int r = 0; r < lim; r++) begin
          if (room_contains(r, px, py)) begin
            res.found = 1;
            res.room = 3'(r);
            res.conf = centre_confidence(r, px, py);
            break;
          end
        end
      end
      res.x = 32'(px);
      res.y = 32'(py);
      pending.push_back(res);
    endfunction

    // accepted input transfer
    function void note_input(cmd_item_t it);
      case (it.cmd)
        CMD_WR_VERT: begin
          vx[it.rslot*NVERTS + it.vslot] = it.x;
          vy[it.rslot*NVERTS + it.vslot] = it.y;
        end
        CMD_WR_ROOM: begin
          cx[it.rslot] = it.x;
          cy[it.rslot] = it.y;
          vcount[it.rslot] = (it.total > NVERTS) ? 5'(NVERTS) : it.total;
        end
        CMD_CLASSIFY: classify_point(it);
        default: ;
      endcase
    endfunction

    // accepted output transfer
    function void check_result(class_result_t got);
      class_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.found) matched++;
      if (got.clamped) clamped_cnt++;
      if (got.x !== exp_r.x) begin
        $display("%0t: pos_x expected %h actual %h", $time, exp_r.x, got.x);
        errors++;
      end
      if (got.y !== exp_r.y) begin
        $display("%0t: pos_y expected %h actual %h", $time, exp_r.y, got.y);
        errors++;
      end
      if (got.clamped !== exp_r.clamped) begin
        $display("%0t: was_clamped expected %b actual %b", $time, exp_r.clamped, got.clamped);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $display("%0t: room_found expected %b actual %b", $time, exp_r.found, got.found);
        errors++;
      end
      if (got.room !== exp_r.room) begin
        $display("%0t: matched_room expected %0d actual %0d", $time, exp_r.room, got.room);
        errors++;
      end
      if (got.conf !== exp_r.conf) begin
        $display("%0t: confidence expected %0d actual %0d", $time, exp_r.conf, got.conf);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  room_scoreboard sb;
  int s_idle_pct;
  int m_idle_pct;
  int hold_left;
  int items_sent;
  int phases_run;
  bit vert_written[NROOMS*NVERTS];

  room_position_classifier_top i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result receiver with random stalls and long hold-offs
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[85:0]);
      if (hold_left > 0) begin
        m_tready <= 0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
      end
    end
  end

  function automatic cmd_item_t make_item(logic [1:0] c, int r, int v, logic [31:0] x,
                                          logic [31:0] y, int tot);
    cmd_item_t it;
    it.cmd = c;
    it.rslot = 3'(r);
    it.vslot = 4'(v);
    it.x = x;
    it.y = y;
    it.total = 5'(tot);
    return it;
  endfunction

  task automatic send_item(cmd_item_t it);
    while ($urandom_range(0, 99) < s_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {2'b00, it};
    do @(posedge clk); while (!s_tready);
    sb.note_input(it);
    if (it.cmd != CMD_UNUSED) items_sent++;
    if (it.cmd == CMD_WR_VERT) vert_written[it.rslot*NVERTS + it.vslot] = 1;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [30:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  // wait until every expected result is in, then let the walk settle
  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] area_coord(logic [30:0] lim);
    return 32'($urandom_range(0, 32'(lim)));
  endfunction

  // vertex writes followed by the header of one room
  task automatic load_room(int r);
    int n;
    logic [31:0] xa, xb, ya, yb, t;
    if ($urandom_range(0, 1)) begin
      xa = area_coord(sb.width_q);
      xb = area_coord(sb.width_q);
      ya = area_coord(sb.height_q);
      yb = area_coord(sb.height_q);
      if (xa > xb) begin t = xa; xa = xb; xb = t; end
      if (ya > yb) begin t = ya; ya = yb; yb = t; end
      n = 4;
      send_item(make_item(CMD_WR_VERT, r, 0, xa, ya, 0));
      send_item(make_item(CMD_WR_VERT, r, 1, xb, ya, 0));
      send_item(make_item(CMD_WR_VERT, r, 2, xb, yb, 0));
      send_item(make_item(CMD_WR_VERT, r, 3, xa, yb, 0));
    end else begin
      n = $urandom_range(3, NVERTS);
      for (int v = 0; v < n; v++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(make_item(CMD_WR_VERT, r, v, $urandom, $urandom, 0));
        else
          send_item(make_item(CMD_WR_VERT, r, v, area_coord(sb.width_q),
                              area_coord(sb.height_q), 0));
      end
    end
    send_item(make_item(CMD_WR_ROOM, r, $urandom_range(0, 15), area_coord(sb.width_q),
                        area_coord(sb.height_q), n));
  endtask

  // query point: in the area, at or next to a vertex, at or next to a clamp bound, or anywhere
  task automatic send_query();
    int sel;
    int r;
    int k;
    longint m, xh, yh;
    logic [31:0] x, y;
    sel = $urandom_range(0, 99);
    m = sb.margin_q;
    xh = longint'(sb.width_q) - m;
    yh = longint'(sb.height_q) - m;
    x = area_coord(sb.width_q);
    y = area_coord(sb.height_q);
    if (sel < 25) begin
      r = $urandom_range(0, NROOMS - 1);
      if (sb.vcount[r] >= 3) begin
        k = r * NVERTS + $urandom_range(0, sb.vcount[r] - 1);
        x = sb.vx[k] + 32'($signed($urandom_range(0, 2)) - 1);
        y = sb.vy[k] + 32'($signed($urandom_range(0, 2)) - 1);
      end
    end else if (sel < 35) begin
      case ($urandom_range(0, 3))
        0: x = 32'(m + $urandom_range(0, 2) - 1);
        1: x = 32'(xh + $urandom_range(0, 2) - 1);
        2: y = 32'(m + $urandom_range(0, 2) - 1);
        default: y = 32'(yh + $urandom_range(0, 2) - 1);
      endcase
    end else if (sel < 45) begin
      x = $urandom;
      y = $urandom;
    end
    send_item(make_item(CMD_CLASSIFY, $urandom, $urandom, x, y, $urandom));
  endtask

  // random vertex or header rewrite, keeping every read entry written
  task automatic send_random_write();
    int r;
    int tot;
    int eff;
    r = $urandom_range(0, NROOMS - 1);
    if ($urandom_range(0, 2) != 0) begin
      send_item(make_item(CMD_WR_VERT, r, $urandom_range(0, NVERTS - 1),
                          ($urandom_range(0, 7) == 0) ? $urandom : area_coord(sb.width_q),
                          ($urandom_range(0, 7) == 0) ? $urandom : area_coord(sb.height_q),
                          $urandom));
    end else begin
      tot = $urandom_range(0, 31);
      eff = (tot > NVERTS) ? NVERTS : tot;
      if (eff >= 3)
        for (int v = 0; v < eff; v++)
          if (!vert_written[r*NVERTS + v])
            send_item(make_item(CMD_WR_VERT, r, v, area_coord(sb.width_q),
                                area_coord(sb.height_q), 0));
      send_item(make_item(CMD_WR_ROOM, r, $urandom, area_coord(sb.width_q),
                          area_coord(sb.height_q), tot));
    end
  endtask

  task automatic random_items(int count);
    int sel;
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) send_query();
      else if (sel < 95) send_random_write();
      else send_item(make_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  // main sequence
  initial begin
    logic [30:0] w, h, mg, dq;
    logic [3:0] ru;
    sb = new();
    sb.reset_state();
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    hold_left = 0;
    items_sent = 0;
    phases_run = 0;
    s_idle_pct = 19;
    m_idle_pct = 56;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: triangle room, saturated 16-vertex room, two-vertex room
    write_reg(CFG_ROOM_WIDTH, 31'd655360);
    write_reg(CFG_ROOM_HEIGHT, 31'd655360);
    write_reg(CFG_EDGE_MARGIN, 31'd65536);
    write_reg(CFG_FULL_DIST, 31'd196608);
    write_reg(CFG_ROOMS_IN_USE, 31'd3);
    send_item(make_item(CMD_WR_VERT, 0, 0, 32'd131072, 32'd131072, 0));
    send_item(make_item(CMD_WR_VERT, 0, 1, 32'd262144, 32'd131072, 0));
    send_item(make_item(CMD_WR_VERT, 0, 2, 32'd131072, 32'd262144, 0));
    send_item(make_item(CMD_WR_ROOM, 0, 0, 32'd163840, 32'd163840, 3));
    for (int i = 0; i < 8; i++) begin
      send_item(make_item(CMD_WR_VERT, 1, i, 32'(327680 + i*16384), 32'd327680, 0));
      send_item(make_item(CMD_WR_VERT, 1, 15 - i, 32'(327680 + i*16384), 32'd589824, 0));
    end
    send_item(make_item(CMD_WR_ROOM, 1, 0, 32'd393216, 32'd458752, 31));
    send_item(make_item(CMD_WR_ROOM, 2, 7, 32'hFFFFFFFF, 32'h80000000, 2));
    send_item(make_item(CMD_CLASSIFY, 7, 15, 32'd163840, 32'd163840, 31));
    send_item(make_item(CMD_CLASSIFY, 0, 0, 32'd131072, 32'd131072, 0));
    send_item(make_item(CMD_CLASSIFY, 0, 0, 32'd400000, 32'd500000, 0));
    send_item(make_item(CMD_CLASSIFY, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0));
    send_item(make_item(CMD_CLASSIFY, 0, 0, 32'd589824, 32'd65537, 0));
    send_item(make_item(CMD_UNUSED, 7, 15, 32'hFFFFFFFF, 32'hFFFFFFFF, 31));
    drain();

    // configuration phases
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin s_idle_pct = 56; m_idle_pct = 19; end
      if (p == 6) begin s_idle_pct = 0; m_idle_pct = 0; end
      w = 31'($urandom_range(131072, 2097152));
      h = 31'($urandom_range(131072, 2097152));
      mg = 31'($urandom_range(0, 32768));
      dq = 31'($urandom_range(1, 1048576));
      ru = 4'($urandom_range(1, 8));
      case (p)
        1: begin w = 31'h7FFFFFFF; h = 31'h7FFFFFFF; mg = 31'd0; dq = 31'h7FFFFFFF; ru = 4'd15; end
        2: dq = 31'd1;
        4: begin w = 31'd0; h = 31'd0; ru = 4'd0; end
        5: begin mg = 31'h7FFFFFFF; dq = 31'd0; end
        7: begin ru = 4'd9; dq = 31'h7FFFFFFF; end
        default: ;
      endcase
      write_reg(CFG_ROOM_WIDTH, w);
      write_reg(CFG_ROOM_HEIGHT, h);
      write_reg(CFG_EDGE_MARGIN, mg);
      write_reg(CFG_FULL_DIST, dq);
      write_reg(CFG_ROOMS_IN_USE, 31'(ru));
      for (int r = 0; r < 3; r++) load_room($urandom_range(0, NROOMS - 1));
      // long receiver hold-off while queries keep coming
      if (p == 2) begin
        hold_left = 3000;
        for (int i = 0; i < 10; i++) send_query();
      end
      random_items(38);
      // sender pause until the pipeline is empty
      if (p == 4) drain();
      random_items(38);
      drain();
      phases_run++;
    end

    $display("covered %0d accepted items over %0d configuration phases", items_sent,
             phases_run + 1);
    $display("checked %0d results: %0d in a room, %0d clamped", sb.checked, sb.matched,
             sb.clamped_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
